// File: hdl/uart_frame_receiver_xor_check_defines.svh
// ----------------------------------------------------------------------------
// uart frame receiver assertion macros
// checks sampled on the rising edge of clk; UFRX_ASSERT checks are off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef UART_FRAME_RECEIVER_XOR_CHECK_DEFINES_SVH
`define UART_FRAME_RECEIVER_XOR_CHECK_DEFINES_SVH

// property that holds at every edge once out of reset
`define UFRX_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property whose trigger needs no reset masking
`define UFRX_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/ufrx_pkg.sv
// ----------------------------------------------------------------------------
// ufrx_pkg
// types and constants shared by the uart frame receiver
// ----------------------------------------------------------------------------
package ufrx_pkg;

	// largest frame in bytes, header and checksum included
	localparam int MAX_FRAME = 256;
	localparam logic [8:0] MAX_LEN = 9'(MAX_FRAME - 5);

	localparam logic [7:0] START_DEFAULT = 8'h0D;
	localparam logic [7:0] CMD_HELLO = 8'h01;
	localparam logic [7:0] CMD_GOODBYE = 8'h02;

	// register indexes
	localparam logic [0:0] REG_START_CODE = 1'b0;

	// frame queue between parser and result stage
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);
	localparam int QPW = QAW + 1;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_ADDR    = 3'd1,
		PH_CMD     = 3'd2,
		PH_LEN     = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_CHECK   = 3'd5
	} parse_phase_t;

	typedef enum logic [2:0] {
		ST_HELLO   = 3'd0,
		ST_GOODBYE = 3'd1,
		ST_UNKNOWN = 3'd2,
		ST_BADSUM  = 3'd3,
		ST_TOOLONG = 3'd4
	} frame_status_t;

	// one finished frame as left by the parser
	typedef struct packed {
		logic       too_long;
		logic       sum_ok;
		logic [7:0] address;
		logic [7:0] command;
		logic [7:0] length;
		logic [7:0] xr;
	} frame_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// File: hdl/ufrx_front.sv
// ----------------------------------------------------------------------------
// ufrx_front
// byte parser: frames start, address, command, length, payload, checksum
// ----------------------------------------------------------------------------
module ufrx_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rx_valid,
	output logic                  rx_ready,
	input  logic [7:0]            rx_byte,
	input  logic [7:0]            start_code,
	input  ufrx_pkg::q_stat_t     q_stat,
	output logic                  push,
	output ufrx_pkg::frame_rec_t  push_data
);

	ufrx_pkg::parse_phase_t phase_q, phase_nxt;
	logic [7:0] addr_q, cmd_q, len_q, left_q, xor_q;
	logic       accept;

	assign rx_ready = !q_stat.full;
	assign accept   = rx_valid && rx_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ufrx_pkg::PH_HUNT;
		end else if (accept) begin
			phase_q <= phase_nxt;
		end
	end

	always_comb begin
		phase_nxt          = phase_q;
		push               = 1'b0;
		push_data.too_long = 1'b0;
		push_data.sum_ok   = (rx_byte == xor_q);
		push_data.address  = addr_q;
		push_data.command  = cmd_q;
		push_data.length   = len_q;
		push_data.xr       = xor_q;
		case (phase_q)
			ufrx_pkg::PH_ADDR: begin
				phase_nxt = ufrx_pkg::PH_CMD;
			end
			ufrx_pkg::PH_CMD: begin
				phase_nxt = ufrx_pkg::PH_LEN;
			end
			ufrx_pkg::PH_LEN: begin
				if ({1'b0, rx_byte} > ufrx_pkg::MAX_LEN) begin
					// oversize length closes the frame on the spot
					push               = accept;
					push_data.too_long = 1'b1;
					push_data.length   = rx_byte;
					push_data.xr       = xor_q ^ rx_byte;
					phase_nxt          = ufrx_pkg::PH_HUNT;
				end else if (rx_byte == 8'd0) begin
					phase_nxt = ufrx_pkg::PH_CHECK;
				end else begin
					phase_nxt = ufrx_pkg::PH_PAYLOAD;
				end
			end
			ufrx_pkg::PH_PAYLOAD: begin
				if (left_q == 8'd1) begin
					phase_nxt = ufrx_pkg::PH_CHECK;
				end
			end
			ufrx_pkg::PH_CHECK: begin
				push      = accept;
				phase_nxt = ufrx_pkg::PH_HUNT;
			end
			default: begin
				// hunting, and any unused phase code
				if (rx_byte == start_code) begin
					phase_nxt = ufrx_pkg::PH_ADDR;
				end else begin
					phase_nxt = ufrx_pkg::PH_HUNT;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			case (phase_q)
				ufrx_pkg::PH_ADDR: begin
					addr_q <= rx_byte;
					xor_q  <= xor_q ^ rx_byte;
				end
				ufrx_pkg::PH_CMD: begin
					cmd_q <= rx_byte;
					xor_q <= xor_q ^ rx_byte;
				end
				ufrx_pkg::PH_LEN: begin
					len_q  <= rx_byte;
					left_q <= rx_byte;
					xor_q  <= xor_q ^ rx_byte;
				end
				ufrx_pkg::PH_PAYLOAD: begin
					left_q <= left_q - 8'd1;
					xor_q  <= xor_q ^ rx_byte;
				end
				ufrx_pkg::PH_CHECK: begin
					xor_q <= xor_q;
				end
				default: begin
					if (rx_byte == start_code) begin
						xor_q <= rx_byte;
					end
				end
			endcase
		end
	end

endmodule

// File: hdl/ufrx_queue.sv
// ----------------------------------------------------------------------------
// ufrx_queue
// small frame queue between the parser and the result stage
// ----------------------------------------------------------------------------
module ufrx_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ufrx_pkg::frame_rec_t  push_data,
	input  logic                  pop,
	output ufrx_pkg::frame_rec_t  pop_data,
	output ufrx_pkg::q_stat_t     stat
);

	ufrx_pkg::frame_rec_t entry_q [ufrx_pkg::QDEPTH];
	logic [ufrx_pkg::QPW-1:0] wr_ptr_q, rd_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + ufrx_pkg::QPW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + ufrx_pkg::QPW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q[ufrx_pkg::QAW-1:0]] <= push_data;
		end
	end

	assign pop_data   = entry_q[rd_ptr_q[ufrx_pkg::QAW-1:0]];
	assign stat.empty = (wr_ptr_q == rd_ptr_q);
	// same slot, opposite lap
	assign stat.full  = (wr_ptr_q[ufrx_pkg::QAW] != rd_ptr_q[ufrx_pkg::QAW]) &&
		(wr_ptr_q[ufrx_pkg::QAW-1:0] == rd_ptr_q[ufrx_pkg::QAW-1:0]);

endmodule

// File: hdl/ufrx_back.sv
// ----------------------------------------------------------------------------
// ufrx_back
// result stage: decodes frame status and holds the output register
// ----------------------------------------------------------------------------
module ufrx_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ufrx_pkg::q_stat_t     q_stat,
	output logic                  pop,
	input  ufrx_pkg::frame_rec_t  pop_data,
	output logic                  frame_valid,
	input  logic                  frame_ready,
	output logic [2:0]            frame_status,
	output logic [7:0]            frame_address,
	output logic [7:0]            frame_command,
	output logic [7:0]            frame_length,
	output logic [7:0]            computed_xor
);

	ufrx_pkg::frame_status_t status_nxt, status_q;
	logic       valid_q;
	logic [7:0] addr_q, cmd_q, len_q, xor_q;

	assign pop = !q_stat.empty && (!valid_q || frame_ready);

	always_comb begin
		if (pop_data.too_long) begin
			status_nxt = ufrx_pkg::ST_TOOLONG;
		end else if (!pop_data.sum_ok) begin
			status_nxt = ufrx_pkg::ST_BADSUM;
		end else if (pop_data.command == ufrx_pkg::CMD_HELLO) begin
			status_nxt = ufrx_pkg::ST_HELLO;
		end else if (pop_data.command == ufrx_pkg::CMD_GOODBYE) begin
			status_nxt = ufrx_pkg::ST_GOODBYE;
		end else begin
			status_nxt = ufrx_pkg::ST_UNKNOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (frame_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= status_nxt;
			addr_q   <= pop_data.address;
			cmd_q    <= pop_data.command;
			len_q    <= pop_data.length;
			xor_q    <= pop_data.xr;
		end
	end

	assign frame_valid   = valid_q;
	assign frame_status  = status_q;
	assign frame_address = addr_q;
	assign frame_command = cmd_q;
	assign frame_length  = len_q;
	assign computed_xor  = xor_q;

endmodule

// File: hdl/uart_frame_receiver_xor_check.sv
// ----------------------------------------------------------------------------
// uart_frame_receiver_xor_check
// frames received uart bytes and checks each frame's xor checksum
// ----------------------------------------------------------------------------
// Bytes arrive one per transfer on rx_* and are framed as start byte, address,
// command, length, length payload bytes and one checksum byte; bytes seen while
// hunting that do not match start_code (APB register at byte address 0, reset
// 0x0D) are dropped. Every finished frame gives one transfer on frame_*: status
// (hello, goodbye, unknown command, checksum error, or length too long, the
// last raised as soon as a length above MAX_FRAME-5 is seen), the header bytes
// and the xor of all frame bytes before the checksum. The parser takes one
// byte every cycle while rx_ready is high; a finished frame is handed to the
// result stage through a four-entry queue, so rx_ready only drops once four
// frames wait behind an output that is not being taken. A result is first
// written into the queue and then into the output register. Payload bytes
// are not kept.
// ----------------------------------------------------------------------------
`include "uart_frame_receiver_xor_check_defines.svh"

module uart_frame_receiver_xor_check (
	input  logic        clk,
	input  logic        arst_n,
	// received byte transfers
	input  logic        rx_valid,
	output logic        rx_ready,
	input  logic [7:0]  rx_byte,
	// frame result transfers
	output logic        frame_valid,
	input  logic        frame_ready,
	output logic [2:0]  frame_status,
	output logic [7:0]  frame_address,
	output logic [7:0]  frame_command,
	output logic [7:0]  frame_length,
	output logic [7:0]  computed_xor,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0]           start_code_q;
	logic                 cfg_wr;
	logic                 q_push, q_pop;
	ufrx_pkg::frame_rec_t q_wdata, q_rdata;
	ufrx_pkg::q_stat_t    q_stat;

	// register port: no wait states, word index taken from paddr[2]
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_code_q <= ufrx_pkg::START_DEFAULT;
		end else if (cfg_wr && (paddr[2:2] == ufrx_pkg::REG_START_CODE)) begin
			start_code_q <= pwdata[7:0];
		end
	end

	// addresses beyond the register read as zero
	assign prdata = (paddr[2:2] == ufrx_pkg::REG_START_CODE) ?
		{24'd0, start_code_q} : 32'd0;

	// parser: classifies each byte, pushes a record when a frame closes
	ufrx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_valid   (rx_valid),
		.rx_ready   (rx_ready),
		.rx_byte    (rx_byte),
		.start_code (start_code_q),
		.q_stat     (q_stat),
		.push       (q_push),
		.push_data  (q_wdata)
	);

	// decouples the parser from output stalls
	ufrx_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.stat      (q_stat)
	);

	// status decode and output register
	ufrx_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_stat        (q_stat),
		.pop           (q_pop),
		.pop_data      (q_rdata),
		.frame_valid   (frame_valid),
		.frame_ready   (frame_ready),
		.frame_status  (frame_status),
		.frame_address (frame_address),
		.frame_command (frame_command),
		.frame_length  (frame_length),
		.computed_xor  (computed_xor)
	);

	// the parser must never write into a full queue
	`UFRX_ASSERT(a_no_push_full, q_push |-> !q_stat.full, "frame pushed into full queue")

	// a new result only follows a record taken from the queue
	`UFRX_ASSERT(a_valid_from_pop, $rose(frame_valid) |-> $past(q_pop), "result without queue pop")

	// too-long status only for a length beyond the frame limit
	`UFRX_ASSERT(a_toolong_len,
		frame_valid && (frame_status == ufrx_pkg::ST_TOOLONG) |->
		({1'b0, frame_length} > ufrx_pkg::MAX_LEN), "too-long status with legal length")

	// no result is pending while reset is held
	`UFRX_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !frame_valid, "result valid during reset")

endmodule

// File: bench/tb_uart_frame_receiver_xor_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uart_frame_receiver_xor_check
// self-checking bench for the uart frame receiver with xor checksum
// ----------------------------------------------------------------------------
// A short directed table runs first. It covers noise, a hello frame of zero
// length, frames whose length is too long, an unknown command and a bad
// checksum. Random frame streams follow, under four start codes and three
// idling patterns. Noise bytes and truncated headers are mixed into the
// streams. In one phase the result side holds off for a long time, so that
// the frame queue fills and back-pressures the byte input. A parser model in
// the bench predicts every frame result not typed into the table. Each result
// transfer is checked, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_uart_frame_receiver_xor_check;

	localparam int          SETTLE_CYCLES = 8;
	localparam int          CYCLE_LIMIT   = 150000;
	localparam int          STALL_CYCLES  = 300;
	localparam logic [2:0]  START_ADDR    = 3'(4 * ufrx_pkg::REG_START_CODE);

	// one frame result as seen on the frame_* port
	typedef struct packed {
		ufrx_pkg::frame_status_t status;
		logic [7:0]              address;
		logic [7:0]              command;
		logic [7:0]              length;
		logic [7:0]              xr;
	} frame_res_t;

	// one row of the directed table: a byte, and where it closes a frame whose
	// result is obvious by eye, that result typed in
	typedef struct packed {
		logic [7:0] b;
		bit         typed;
		frame_res_t res;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b1;
	logic        rx_valid = 1'b0;
	logic        rx_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        frame_valid;
	logic        frame_ready = 1'b0;
	logic [2:0]  frame_status;
	logic [7:0]  frame_address;
	logic [7:0]  frame_command;
	logic [7:0]  frame_length;
	logic [7:0]  computed_xor;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'h0;
	logic [31:0] prdata;
	logic        pready;

	// parser model state, mirrors the block's own
	ufrx_pkg::parse_phase_t pr_phase = ufrx_pkg::PH_HUNT;
	logic [7:0]   pr_addr = 8'h00;
	logic [7:0]   pr_cmd = 8'h00;
	logic [7:0]   pr_len = 8'h00;
	logic [7:0]   pr_left = 8'h00;
	logic [7:0]   pr_xor = 8'h00;
	logic [7:0]   cfg_start = ufrx_pkg::START_DEFAULT;

	frame_res_t   pending_frames[$];
	dir_row_t     dir_rows[25];
	int           err_count = 0;
	int           frame_bytes = 0;
	int           cycle_count = 0;
	int           tx_idle_pct = 0;
	int           rx_idle_pct = 0;
	bit           hold_go = 1'b0;
	bit           stall_rx = 1'b0;

	uart_frame_receiver_xor_check dut (.*);

	always #4 clk = ~clk;

	// -------------------------------------------------------------------------
	// parser model: one byte in, at most one frame result out
	// -------------------------------------------------------------------------
	function automatic bit parse_byte(input logic [7:0] b, output frame_res_t res);
		bit                      done;
		ufrx_pkg::frame_status_t st;
		done = 1'b0;
		res = '0;
		case (pr_phase)
			ufrx_pkg::PH_ADDR: begin
				pr_addr = b;
				pr_xor ^= b;
				pr_phase = ufrx_pkg::PH_CMD;
			end
			ufrx_pkg::PH_CMD: begin
				pr_cmd = b;
				pr_xor ^= b;
				pr_phase = ufrx_pkg::PH_LEN;
			end
			ufrx_pkg::PH_LEN: begin
				pr_len = b;
				pr_xor ^= b;
				if ({1'b0, b} > ufrx_pkg::MAX_LEN) begin
					// too long: reported at once, back to hunting
					pr_phase = ufrx_pkg::PH_HUNT;
					res = '{ufrx_pkg::ST_TOOLONG, pr_addr, pr_cmd, pr_len, pr_xor};
					done = 1'b1;
				end else begin
					pr_left = b;
					pr_phase = (b == 8'h00) ? ufrx_pkg::PH_CHECK : ufrx_pkg::PH_PAYLOAD;
				end
			end
			ufrx_pkg::PH_PAYLOAD: begin
				pr_xor ^= b;
				pr_left -= 8'd1;
				if (pr_left == 8'h00)
					pr_phase = ufrx_pkg::PH_CHECK;
			end
			ufrx_pkg::PH_CHECK: begin
				// command only decoded when the checksum holds
				if (b != pr_xor)
					st = ufrx_pkg::ST_BADSUM;
				else if (pr_cmd == ufrx_pkg::CMD_HELLO)
					st = ufrx_pkg::ST_HELLO;
				else if (pr_cmd == ufrx_pkg::CMD_GOODBYE)
					st = ufrx_pkg::ST_GOODBYE;
				else
					st = ufrx_pkg::ST_UNKNOWN;
				res = '{st, pr_addr, pr_cmd, pr_len, pr_xor};
				pr_phase = ufrx_pkg::PH_HUNT;
				done = 1'b1;
			end
			default: begin
				// hunting, unused codes included: noise is dropped
				if (b == cfg_start) begin
					pr_xor = b;
					pr_phase = ufrx_pkg::PH_ADDR;
				end else begin
					pr_phase = ufrx_pkg::PH_HUNT;
				end
			end
		endcase
		return done;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
		err_count++;
	endtask

	// -------------------------------------------------------------------------
	// byte sender: random gaps, valid held until the transfer, then predict
	// -------------------------------------------------------------------------
	task automatic put_byte(input logic [7:0] b, input bit fixed = 1'b0,
			input frame_res_t fixed_res = '0);
		frame_res_t res;
		while ($urandom_range(99) < tx_idle_pct) begin
			rx_valid <= 1'b0;
			rx_byte <= 8'($urandom);
			@(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!rx_ready);
		// transfer taken at this edge
		if (parse_byte(b, res))
			pending_frames.push_back(fixed ? fixed_res : res);
		@(negedge clk);
	endtask

	// one frame with the current start code; corrupt spoils the checksum
	task automatic send_frame(input logic [7:0] adr, input logic [7:0] cmd,
			input logic [7:0] len, input bit corrupt);
		logic [7:0] sum;
		logic [7:0] pb;
		sum = cfg_start ^ adr ^ cmd ^ len;
		put_byte(cfg_start);
		put_byte(adr);
		put_byte(cmd);
		put_byte(len);
		frame_bytes += 4;
		if ({1'b0, len} <= ufrx_pkg::MAX_LEN) begin
			for (int i = 0; i < int'(len); i++) begin
				pb = 8'($urandom);
				sum ^= pb;
				put_byte(pb);
			end
			if (corrupt)
				sum ^= 8'($urandom_range(1, 255));
			put_byte(sum);
			frame_bytes += int'(len) + 1;
		end
	endtask

	// mostly well-formed frames, with noise and truncated headers in between
	task automatic run_stream(input int n_bytes);
		int         base;
		int         r;
		logic [7:0] nb;
		logic [7:0] cmd;
		logic [7:0] len;
		base = frame_bytes;
		while (frame_bytes - base < n_bytes) begin
			r = $urandom_range(99);
			if (r < 12) begin
				repeat ($urandom_range(1, 3)) begin
					do nb = 8'($urandom); while (nb == cfg_start);
					put_byte(nb);
				end
			end else if (r < 16) begin
				// header cut short: the next frame is swallowed into it
				put_byte(cfg_start);
				repeat ($urandom_range(0, 2)) put_byte(8'($urandom));
			end
			r = $urandom_range(9);
			cmd = (r < 4) ? ufrx_pkg::CMD_HELLO :
				(r < 7) ? ufrx_pkg::CMD_GOODBYE : 8'($urandom);
			r = $urandom_range(99);
			if (r < 6)
				len = 8'($urandom_range(int'(ufrx_pkg::MAX_LEN) + 1, 255));
			else if (r < 7)
				len = ufrx_pkg::MAX_LEN[7:0];
			else
				len = 8'($urandom_range(0, 6));
			send_frame(8'($urandom), cmd, len, $urandom_range(7) == 0);
		end
	endtask

	// stop sending, let every expected frame drain and the parser go quiet
	task automatic drain;
		rx_valid <= 1'b0;
		while (pending_frames.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// register write followed by a readback, both as setup plus access
	task automatic write_start_code(input logic [7:0] code);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= START_ADDR;
		pwdata <= {24'h0, code};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {24'h0, code})
			report_mismatch("start_code readback", int'(prdata), int'(code));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		cfg_start = code;
	endtask

	// -------------------------------------------------------------------------
	// result side: random hold-off, plus one long stall on request
	// -------------------------------------------------------------------------
	always @(negedge clk) begin
		frame_ready <= !stall_rx && ($urandom_range(99) >= rx_idle_pct);
	end

	initial begin
		wait (hold_go);
		@(posedge clk);
		stall_rx = 1'b1;
		repeat (STALL_CYCLES) @(posedge clk);
		stall_rx = 1'b0;
	end

	always @(posedge clk) begin : result_check
		frame_res_t want;
		if (arst_n && frame_valid && frame_ready) begin
			if (pending_frames.size() == 0) begin
				report_mismatch("frame with none expected, status", int'(frame_status), 0);
			end else begin
				want = pending_frames.pop_front();
				if (frame_status !== want.status)
					report_mismatch("frame_status", int'(frame_status), int'(want.status));
				if (frame_address !== want.address)
					report_mismatch("frame_address", int'(frame_address), int'(want.address));
				if (frame_command !== want.command)
					report_mismatch("frame_command", int'(frame_command), int'(want.command));
				if (frame_length !== want.length)
					report_mismatch("frame_length", int'(frame_length), int'(want.length));
				if (computed_xor !== want.xr)
					report_mismatch("computed_xor", int'(computed_xor), int'(want.xr));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// -------------------------------------------------------------------------
	// stimulus
	// -------------------------------------------------------------------------
	initial begin
		// reset edge at time zero so the block clears before the first clock
		arst_n <= 1'b0;
		dir_rows = '{
			// noise while hunting, dropped
			'{8'hFF, 1'b0, '0},
			// hello, zero length, checksum straight after the length byte
			'{8'h0D, 1'b0, '0},
			'{8'h00, 1'b0, '0},
			'{8'h01, 1'b0, '0},
			'{8'h00, 1'b0, '0},
			'{8'h0C, 1'b1, '{ufrx_pkg::ST_HELLO, 8'h00, 8'h01, 8'h00, 8'h0C}},
			// largest length byte, rejected on the spot
			'{8'h0D, 1'b0, '0},
			'{8'h80, 1'b0, '0},
			'{8'h7F, 1'b0, '0},
			'{8'hFF, 1'b1, '{ufrx_pkg::ST_TOOLONG, 8'h80, 8'h7F, 8'hFF, 8'h0D}},
			// one above the longest allowed length
			'{8'h0D, 1'b0, '0},
			'{8'hFF, 1'b0, '0},
			'{8'h02, 1'b0, '0},
			'{8'hFC, 1'b1, '{ufrx_pkg::ST_TOOLONG, 8'hFF, 8'h02, 8'hFC, 8'h0C}},
			// unknown command with one payload byte, good checksum
			'{8'h0D, 1'b0, '0},
			'{8'h12, 1'b0, '0},
			'{8'hFF, 1'b0, '0},
			'{8'h01, 1'b0, '0},
			'{8'hAA, 1'b0, '0},
			'{8'h4B, 1'b0, '0},
			// goodbye with a wrong checksum: command not decoded
			'{8'h0D, 1'b0, '0},
			'{8'h34, 1'b0, '0},
			'{8'h02, 1'b0, '0},
			'{8'h00, 1'b0, '0},
			'{8'h00, 1'b1, '{ufrx_pkg::ST_BADSUM, 8'h34, 8'h02, 8'h00, 8'h3B}}
		};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// phase one: reset start code, sender idles a little, receiver a lot
		tx_idle_pct = 24;
		rx_idle_pct = 56;
		foreach (dir_rows[i])
			put_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].res);
		run_stream(350);
		drain();

		// phase two: lowest start code, idling the other way round
		write_start_code(8'h00);
		tx_idle_pct = 56;
		rx_idle_pct = 24;
		run_stream(350);
		drain();

		// phase three: highest start code, back to back transfers
		write_start_code(8'hFF);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_stream(350);
		drain();

		// phase four: arbitrary start code; the result side stalls while short
		// hello frames keep coming, so the queue fills and rx_ready drops
		write_start_code(8'($urandom_range(1, 254)));
		hold_go <= 1'b1;
		repeat (16) send_frame(8'($urandom), ufrx_pkg::CMD_HELLO, 8'h00, 1'b0);
		run_stream(330);
		drain();

		if (pending_frames.size() != 0)
			report_mismatch("frames never delivered", pending_frames.size(), 0);
		if (err_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
